>>> rtl/core/qpr_pkg.sv
package qpr_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int COMP_W = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int SAT_W = 72;
   // quotient bits of the divider, the top one only flags overflow
   localparam int QUO_W = COMP_W + 2;

   localparam logic [1:0] OP_PRODUCT = 2'd0;
   localparam logic [1:0] OP_ROT_UNIT = 2'd1;
   localparam logic [1:0] OP_ROT_GEN = 2'd2;

   localparam logic [COMP_W-1:0] Q_MAX_VAL = 32'h7FFF_FFFF;
   localparam logic [COMP_W-1:0] Q_MIN_VAL = 32'h8000_0000;
   localparam logic [COMP_W:0] QUO_BIG = 33'h1_0000_0000;
   localparam logic [COMP_W:0] NEG_LIMIT = 33'h0_8000_0000;
   localparam logic [COMP_W:0] POS_LIMIT = 33'h0_7FFF_FFFF;

   // subtracted terms of the hamilton product, [result][left operand]
   localparam logic [3:0][3:0] HAM_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

   typedef enum logic [1:0] {
      KIND_PRODUCT,
      KIND_UNIT,
      KIND_GENERAL
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [3:0][COMP_W-1:0] b;
      logic [3:0][COMP_W-1:0] a;
   } item_type;

   typedef struct packed {
      logic zero_norm;
      logic saturated;
      logic [3:0][COMP_W-1:0] r;
   } res_type;

   typedef struct packed {
      logic clamp;
      logic [COMP_W-1:0] val;
   } sat_type;

   function automatic int ham_sum_w(input int frac);
      return 2 * (COMP_W + 1) - frac + 2;
   endfunction

   function automatic int norm_w(input int frac);
      return 2 * COMP_W - frac + 1;
   endfunction

   function automatic int num_w(input int frac);
      return ham_sum_w(frac) + frac;
   endfunction

   function automatic sat_type sat32(input logic signed [SAT_W-1:0] v);
      sat_type s;
      s.clamp = !((&v[SAT_W-1:COMP_W-1]) || !(|v[SAT_W-1:COMP_W-1]));
      if (s.clamp) begin
         s.val = v[SAT_W-1] ? Q_MIN_VAL : Q_MAX_VAL;
      end else begin
         s.val = v[COMP_W-1:0];
      end
      return s;
   endfunction

endpackage

>>> rtl/core/quaternion_product_rotate_top.sv
// quaternion unit, signed fixed point with FRAC_BITS fraction bits
// req channel: one beat per item; req_tuser carries the operation
// (product, rotation by a unit quaternion, rotation by a general one),
// req_tdata the two quaternions a and b
// rsp channel: one beat per item, in the order the items came in;
// rsp_tdata holds the result, rsp_tuser the saturated and zero-norm flags
// throughput: one item per cycle on both channels when nothing stalls
// the datapath holds two hamilton product stages, each registering its
// products and then its sums, and a 34-stage restoring divider that
// every item passes through, one quotient bit per stage
// a four-entry input queue decouples the accept side from the datapath
// while a result waits with rsp_tready low the whole datapath holds its contents;
// the queue keeps taking beats until it is full, then req_tready drops
// reset empties the queue and the pipeline; no results are pending after it
module quaternion_product_rotate_top
   import qpr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // a_s, a_i, a_j, a_k, b_s, b_i, b_j, b_k
   input  logic [8*COMP_W-1:0] req_tdata,
   // operation
   input  logic [1:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // r_s, r_i, r_j, r_k
   output logic [4*COMP_W-1:0] rsp_tdata,
   // saturated, zero_norm
   output logic [1:0]          rsp_tuser
);

   logic q_valid;
   item_type q_item;
   logic q_pop;
   res_type res;

   qpr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser),
      .in_data   (req_tdata),
      .out_valid (q_valid),
      .out_item  (q_item),
      .pop       (q_pop)
   );

   qpr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_item   (q_item),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_res   (res),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = res.r;
   assign rsp_tuser = {res.zero_norm, res.saturated};

endmodule

>>> rtl/core/qpr_front.sv
module qpr_front
   import qpr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_op,
   input  logic [8*COMP_W-1:0] in_data,
   output logic              out_valid,
   output item_type          out_item,
   input  logic              pop
);

   item_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0] cnt_ff;
   logic [PTR_W:0] cnt_in;
   logic push;
   logic take;
   item_type wr_item;

   assign in_ready = cnt_ff != (PTR_W+1)'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_item = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign take = pop && out_valid;
   assign cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(take);

   always_comb begin
      wr_item.a = in_data[4*COMP_W-1:0];
      wr_item.b = in_data[8*COMP_W-1:4*COMP_W];
      unique case (in_op)
         OP_ROT_UNIT: wr_item.kind = KIND_UNIT;
         OP_ROT_GEN: wr_item.kind = KIND_GENERAL;
         default: wr_item.kind = KIND_PRODUCT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (take) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wr_item;
   end

endmodule

>>> rtl/core/qpr_ham.sv
module qpr_ham
   import qpr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int IN_W = COMP_W + 1,
   localparam int SUM_W = ham_sum_w(FRAC_BITS)
)
(
   input  logic                  clock,
   input  logic                  en,
   input  logic [3:0][IN_W-1:0]  x,
   input  logic [3:0][IN_W-1:0]  y,
   output logic [3:0][SUM_W-1:0] sum
);

   localparam int PROD_W = 2 * IN_W;

   logic signed [PROD_W-1:0] prod_ff [4][4];
   logic signed [PROD_W-1:0] prod_in [4][4];
   logic signed [SUM_W-1:0] sum_ff [4];
   logic signed [SUM_W-1:0] sum_in [4];
   logic signed [SUM_W-1:0] trm;
   logic signed [SUM_W-1:0] acc;

   // result r takes x[i] times y[r xor i]
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int i = 0; i < 4; i++) begin
            prod_in[r][i] = $signed(x[i]) * $signed(y[r ^ i]);
         end
      end
   end

   always_comb begin
      trm = '0;
      acc = '0;
      for (int r = 0; r < 4; r++) begin
         acc = '0;
         for (int i = 0; i < 4; i++) begin
            trm = SUM_W'(prod_ff[r][i] >>> FRAC_BITS);
            if (HAM_NEG[r][i]) acc = acc - trm;
            else acc = acc + trm;
         end
         sum_in[r] = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         sum_ff <= sum_in;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) sum[r] = sum_ff[r];
   end

endmodule

>>> rtl/core/qpr_div.sv
module qpr_div
   import qpr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int NUM_W = num_w(FRAC_BITS),
   localparam int DEN_W = norm_w(FRAC_BITS)
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic                  in_use_div,
   input  logic [2:0][NUM_W-1:0] in_num,
   input  logic [2:0]            in_neg,
   input  logic [DEN_W-1:0]      in_den,
   input  res_type               in_res,
   output logic                  out_valid,
   output res_type               out_res
);

   localparam int STEPS = QUO_W;
   localparam int CMP_W = (DEN_W + STEPS - 1 > NUM_W) ? DEN_W + STEPS - 1 : NUM_W;

   logic [STEPS:0] v_ff;
   logic [STEPS:0] use_ff;
   logic [NUM_W-1:0] rem_ff [STEPS+1][3];
   logic [NUM_W-1:0] rem_in [STEPS][3];
   logic [QUO_W-1:0] q_ff [STEPS+1][3];
   logic [QUO_W-1:0] q_in [STEPS][3];
   logic [DEN_W-1:0] den_ff [STEPS+1];
   logic [2:0] neg_ff [STEPS+1];
   res_type res_ff [STEPS+1];
   logic [NUM_W:0] st;
   logic [QUO_W-1:0] qf;
   logic [COMP_W:0] qc;
   logic [COMP_W:0] qneg;
   logic [COMP_W-1:0] dval;
   logic dclamp;

   function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem,
                                               input logic [DEN_W-1:0] den,
                                               input int k);
      logic [CMP_W-1:0] dsh;
      logic [CMP_W-1:0] diff;
      logic ge;
      dsh = CMP_W'(den) << k;
      ge = CMP_W'(rem) >= dsh;
      diff = CMP_W'(rem) - dsh;
      return {ge, ge ? diff[NUM_W-1:0] : rem};
   endfunction

   // one quotient bit per stage, top bit first
   always_comb begin
      st = '0;
      for (int s = 0; s < STEPS; s++) begin
         for (int l = 0; l < 3; l++) begin
            st = div_step(rem_ff[s][l], den_ff[s], STEPS - 1 - s);
            rem_in[s][l] = st[NUM_W-1:0];
            q_in[s][l] = q_ff[s][l];
            q_in[s][l][STEPS-1-s] = st[NUM_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[STEPS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            rem_ff[0][l] <= in_num[l];
            q_ff[0][l] <= '0;
         end
         den_ff[0] <= in_den;
         neg_ff[0] <= in_neg;
         res_ff[0] <= in_res;
         use_ff <= {use_ff[STEPS-1:0], in_use_div};
         for (int s = 0; s < STEPS; s++) begin
            rem_ff[s+1] <= rem_in[s];
            q_ff[s+1] <= q_in[s];
            den_ff[s+1] <= den_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            res_ff[s+1] <= res_ff[s];
         end
      end
   end

   always_comb begin
      out_res = res_ff[STEPS];
      qf = '0;
      qc = '0;
      qneg = '0;
      dval = '0;
      dclamp = 1'b0;
      for (int l = 0; l < 3; l++) begin
         qf = q_ff[STEPS][l];
         if (qf[QUO_W-1] || (qf[QUO_W-2:0] > QUO_BIG)) qc = QUO_BIG;
         else qc = qf[QUO_W-2:0];
         qneg = -qc;
         if (neg_ff[STEPS][l]) begin
            dclamp = qc > NEG_LIMIT;
            dval = dclamp ? Q_MIN_VAL : qneg[COMP_W-1:0];
         end else begin
            dclamp = qc > POS_LIMIT;
            dval = dclamp ? Q_MAX_VAL : qc[COMP_W-1:0];
         end
         if (use_ff[STEPS]) begin
            out_res.r[l+1] = dval;
            out_res.saturated = out_res.saturated | dclamp;
         end
      end
   end

   assign out_valid = v_ff[STEPS];

endmodule

>>> rtl/core/qpr_back.sv
module qpr_back
   import qpr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     pop,
   output logic     out_valid,
   output res_type  out_res,
   input  logic     out_ready
);

   localparam int IN_W = COMP_W + 1;
   localparam int SUM_W = ham_sum_w(FRAC_BITS);
   localparam int NORM_W = norm_w(FRAC_BITS);
   localparam int NUM_W = num_w(FRAC_BITS);

   logic adv;
   logic [3:0] v_ff;
   kind_type kind_ff [4];
   logic [3:0][COMP_W-1:0] a0_ff;
   logic [3:0][COMP_W-1:0] a1_ff;
   logic signed [2*COMP_W-1:0] npr_ff [4];
   logic [NORM_W-1:0] n_in;
   logic [NORM_W-1:0] n1_ff;
   logic [NORM_W-1:0] n2_ff;
   logic [NORM_W-1:0] n3_ff;
   logic [3:0][COMP_W-1:0] t_in;
   logic [3:0][COMP_W-1:0] t2_ff;
   logic [3:0][COMP_W-1:0] t3_ff;
   logic tsat_in;
   logic tsat2_ff;
   logic tsat3_ff;
   logic [3:0][IN_W-1:0] x1;
   logic [3:0][IN_W-1:0] y1;
   logic [3:0][IN_W-1:0] x2;
   logic [3:0][IN_W-1:0] y2;
   logic [3:0][SUM_W-1:0] sum1;
   logic [3:0][SUM_W-1:0] sum2;
   sat_type tq [4];
   sat_type wq [3];
   res_type byp;
   logic use_div;
   logic [2:0][NUM_W-1:0] num;
   logic [2:0] neg;
   logic [SUM_W-1:0] wmag [3];
   logic div_valid;
   res_type div_res;
   logic out_v_ff;
   res_type out_res_ff;

   assign adv = !out_v_ff || out_ready;
   assign pop = adv;

   // rotations use the pure quaternion (0, x, y, z)
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         x1[i] = IN_W'($signed(in_item.a[i]));
         if (in_item.kind == KIND_PRODUCT || i != 0) y1[i] = IN_W'($signed(in_item.b[i]));
         else y1[i] = '0;
      end
   end

   qpr_ham #(.FRAC_BITS(FRAC_BITS)) u_ham_first (
      .clock (clock),
      .en    (adv),
      .x     (x1),
      .y     (y1),
      .sum   (sum1)
   );

   always_comb begin
      n_in = '0;
      for (int i = 0; i < 4; i++) n_in = n_in + NORM_W'(npr_ff[i] >>> FRAC_BITS);
   end

   always_comb begin
      tsat_in = 1'b0;
      for (int i = 0; i < 4; i++) begin
         tq[i] = sat32(SAT_W'($signed(sum1[i])));
         t_in[i] = tq[i].val;
         tsat_in = tsat_in | tq[i].clamp;
         x2[i] = IN_W'($signed(t_in[i]));
         if (i == 0) y2[i] = IN_W'($signed(a1_ff[i]));
         else y2[i] = -IN_W'($signed(a1_ff[i]));
      end
   end

   qpr_ham #(.FRAC_BITS(FRAC_BITS)) u_ham_second (
      .clock (clock),
      .en    (adv),
      .x     (x2),
      .y     (y2),
      .sum   (sum2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            npr_ff[i] <= $signed(in_item.a[i]) * $signed(in_item.a[i]);
         end
         kind_ff[0] <= in_item.kind;
         for (int s = 1; s < 4; s++) kind_ff[s] <= kind_ff[s-1];
         a0_ff <= in_item.a;
         a1_ff <= a0_ff;
         n1_ff <= n_in;
         n2_ff <= n1_ff;
         n3_ff <= n2_ff;
         t2_ff <= t_in;
         t3_ff <= t2_ff;
         tsat2_ff <= tsat_in;
         tsat3_ff <= tsat2_ff;
      end
   end

   // scalar part of the second product is dropped for rotations
   always_comb begin
      byp = '0;
      use_div = 1'b0;
      for (int l = 0; l < 3; l++) begin
         wq[l] = sat32(SAT_W'($signed(sum2[l+1])));
         neg[l] = sum2[l+1][SUM_W-1];
         wmag[l] = neg[l] ? -sum2[l+1] : sum2[l+1];
         num[l] = NUM_W'(wmag[l]) << FRAC_BITS;
      end
      unique case (kind_ff[3])
         KIND_UNIT: begin
            for (int l = 0; l < 3; l++) byp.r[l+1] = wq[l].val;
            byp.saturated = tsat3_ff | wq[0].clamp | wq[1].clamp | wq[2].clamp;
         end
         KIND_GENERAL: begin
            if (n3_ff == '0) begin
               byp.zero_norm = 1'b1;
            end else begin
               use_div = 1'b1;
               byp.saturated = tsat3_ff;
            end
         end
         default: begin
            byp.r = t3_ff;
            byp.saturated = tsat3_ff;
         end
      endcase
   end

   qpr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (v_ff[3]),
      .in_use_div (use_div),
      .in_num     (num),
      .in_neg     (neg),
      .in_den     (n3_ff),
      .in_res     (byp),
      .out_valid  (div_valid),
      .out_res    (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) out_res_ff <= div_res;
   end

   assign out_valid = out_v_ff;
   assign out_res = out_res_ff;

endmodule

>>> sim/tb_quaternion_product_rotate_top.sv
module tb_quaternion_product_rotate_top;
   import qpr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_COUNT = 1900;
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef struct {
      logic signed [31:0] r [4];
      logic saturated;
      logic zero_norm;
   } quat_result_type;

   typedef logic signed [65:0] wide_type;

   // floor shift of one exact product
   function automatic wide_type fx_term(input wide_type x, input wide_type y);
      logic signed [131:0] p;
      p = x * y;
      return wide_type'(p >>> FRAC_BITS_DEF);
   endfunction

   function automatic void hamilton_mul(input wide_type x [4], input wide_type y [4],
                                        output wide_type r [4]);
      r[0] = fx_term(x[0], y[0]) - fx_term(x[1], y[1]) - fx_term(x[2], y[2])
           - fx_term(x[3], y[3]);
      r[1] = fx_term(x[0], y[1]) + fx_term(x[1], y[0]) + fx_term(x[2], y[3])
           - fx_term(x[3], y[2]);
      r[2] = fx_term(x[0], y[2]) - fx_term(x[1], y[3]) + fx_term(x[2], y[0])
           + fx_term(x[3], y[1]);
      r[3] = fx_term(x[0], y[3]) + fx_term(x[1], y[2]) - fx_term(x[2], y[1])
           + fx_term(x[3], y[0]);
   endfunction

   function automatic logic signed [31:0] clamp32(input wide_type v, inout logic flag);
      if (v > 66'sd2147483647) begin
         flag = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -66'sd2147483648) begin
         flag = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // (w << frac) / n truncated toward zero, then clamped
   function automatic logic signed [31:0] norm_divide(input wide_type w, input wide_type n,
                                                     inout logic flag);
      logic [130:0] mag, q;
      mag = (w < 0) ? 131'(-w) : 131'(w);
      q = (mag << FRAC_BITS_DEF) / 131'(n);
      if (w < 0) begin
         if (q > 131'h8000_0000) begin
            flag = 1'b1;
            return 32'sh8000_0000;
         end
         return -q[31:0];
      end
      if (q > 131'h7FFF_FFFF) begin
         flag = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      return q[31:0];
   endfunction

   function automatic quat_result_type quat_predict(input logic [1:0] op,
                                                    input logic [255:0] data);
      quat_result_type res;
      wide_type a [4], b [4], p [4], ca [4], t [4], w [4], r [4], n;
      logic sat;
      sat = 1'b0;
      res.zero_norm = 1'b0;
      for (int x = 0; x < 4; x++) begin
         a[x] = wide_type'($signed(data[32*x +: 32]));
         b[x] = wide_type'($signed(data[128 + 32*x +: 32]));
      end
      if (op == OP_ROT_UNIT || op == OP_ROT_GEN) begin
         p[0] = 0;
         ca[0] = a[0];
         for (int x = 1; x < 4; x++) begin
            p[x] = b[x];
            ca[x] = -a[x];
         end
         hamilton_mul(a, p, t);
         for (int x = 0; x < 4; x++) t[x] = wide_type'(clamp32(t[x], sat));
         hamilton_mul(t, ca, w);
         res.r[0] = 0;
         if (op == OP_ROT_UNIT) begin
            for (int x = 1; x < 4; x++) res.r[x] = clamp32(w[x], sat);
         end else begin
            n = fx_term(a[0], a[0]) + fx_term(a[1], a[1]) + fx_term(a[2], a[2])
              + fx_term(a[3], a[3]);
            if (n <= 0) begin
               res.zero_norm = 1'b1;
               sat = 1'b0;
               for (int x = 1; x < 4; x++) res.r[x] = 0;
            end else begin
               for (int x = 1; x < 4; x++) res.r[x] = norm_divide(w[x], n, sat);
            end
         end
      end else begin
         hamilton_mul(a, b, r);
         for (int x = 0; x < 4; x++) res.r[x] = clamp32(r[x], sat);
      end
      res.saturated = sat;
      return res;
   endfunction

   class quat_scoreboard;
      quat_result_type pending [$];
      int mismatches = 0;
      int checked = 0;
      int sat_seen = 0;
      int zero_norm_seen = 0;

      function void note_item(input logic [1:0] op, input logic [255:0] data);
         pending.push_back(quat_predict(op, data));
      endfunction

      function void check_result(input logic [127:0] data, input logic [1:0] flags);
         quat_result_type exp_res;
         logic bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", data);
            return;
         end
         exp_res = pending.pop_front();
         checked++;
         bad = (flags[0] !== exp_res.saturated) || (flags[1] !== exp_res.zero_norm);
         for (int x = 0; x < 4; x++) bad |= (data[32*x +: 32] !== exp_res.r[x]);
         sat_seen += flags[0];
         zero_norm_seen += flags[1];
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch at result %0d: expected %h %h %h %h sat %b zn %b,",
                         " got %h sat %b zn %b"},
                        checked, exp_res.r[3], exp_res.r[2], exp_res.r[1], exp_res.r[0],
                        exp_res.saturated, exp_res.zero_norm, data, flags[0], flags[1]);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [8*COMP_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [4*COMP_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   quaternion_product_rotate_top dut (.*);

   always #10 clock = ~clock;

   quat_scoreboard board = new();
   int send_idle_pct = 20;
   int recv_idle_pct = 49;
   int hold_off_cycles = 0;
   int cycle_count = 0;
   int op_count [4] = '{0, 0, 0, 0};

   // output side: sample at rising edge, change ready at falling edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0001_0000;
         3: return 32'($signed($urandom_range(131072)) - 65536);
         4: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
         5: return 32'd0;
         default: return $urandom();
      endcase
   endfunction

   // valid stays high between back to back beats, drops only while idling
   task automatic send_item(input logic [1:0] op, input logic [255:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      board.note_item(op, data);
      op_count[op]++;
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [255:0] data;
      logic [1:0] op;
      op = ($urandom_range(19) == 0) ? OP_SPARE : 2'($urandom_range(2));
      for (int x = 0; x < 8; x++) data[32*x +: 32] = rand_comp();
      // unit quaternions near rotations reach deeper than raw noise
      if ($urandom_range(3) == 0) begin
         data[31:0] = 32'($signed($urandom_range(65536)));
         for (int x = 1; x < 4; x++)
            data[32*x +: 32] = 32'($signed($urandom_range(46000)) - 23000);
      end
      send_item(op, data);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [255:0] d;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: identities, extremes, zero norm, all ones, spare opcode
      d = '0; d[31:0] = 32'h0001_0000; d[159:128] = 32'h0001_0000;
      send_item(OP_PRODUCT, d);
      d = '0; d[31:0] = 32'h0001_0000; d[191:160] = 32'h0003_0000;
      send_item(OP_ROT_UNIT, d);
      send_item(OP_ROT_GEN, d);
      d = '0; d[63:32] = 32'h0000_B505; d[31:0] = 32'h0000_B505;
      d[223:192] = 32'h0002_0000;
      send_item(OP_ROT_UNIT, d);
      send_item(OP_ROT_GEN, d);
      d = '0; d[255:160] = {3{32'h0001_0000}};
      send_item(OP_ROT_GEN, d);
      d = '0; d[31:0] = 32'h0000_00FF; d[255:160] = {3{32'h7FFF_FFFF}};
      send_item(OP_ROT_GEN, d);
      d = '0; d[31:0] = 32'h0000_0100; d[191:160] = 32'h7FFF_FFFF;
      send_item(OP_ROT_GEN, d);
      d = {8{32'h8000_0000}};
      for (int o = 0; o < 4; o++) send_item(2'(o), d);
      d = {8{32'h7FFF_FFFF}};
      for (int o = 0; o < 4; o++) send_item(2'(o), d);
      d = '1;
      for (int o = 0; o < 4; o++) send_item(2'(o), d);
      d = '0;
      send_item(OP_ROT_GEN, d);
      send_item(OP_PRODUCT, d);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 49 : 0;
         recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 20 : 0;
         for (int n = 0; n < ITEM_COUNT / 3; n++) begin
            // long receiver stall so the queue fills and req_tready drops
            if (phase == 2 && n == 100) hold_off_cycles = 300;
            send_random();
         end
      end

      drain();
      $display("%0d results checked: %0d product, %0d unit, %0d general, %0d spare code",
               board.checked, op_count[0], op_count[1], op_count[2], op_count[3]);
      $display("flags seen: %0d saturated, %0d zero norm; %0d mismatches",
               board.sat_seen, board.zero_norm_seen, board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

>>> quaternion_product_rotate_top.f
rtl/core/qpr_pkg.sv
rtl/core/qpr_front.sv
rtl/core/qpr_ham.sv
rtl/core/qpr_div.sv
rtl/core/qpr_back.sv
rtl/core/quaternion_product_rotate_top.sv
sim/tb_quaternion_product_rotate_top.sv
